FILE: sv/aim_dwell_burst_trigger_assert.svh
// Assertion macros used by the aim dwell burst trigger mode controller.
// Needs a clk and an active-high rst in the scope of each use.
`ifndef AIM_DWELL_BURST_TRIGGER_ASSERT_SVH
`define AIM_DWELL_BURST_TRIGGER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ABDT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ABDT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/abdt_pkg.sv
// Shared types and constants for the aim dwell burst trigger.
// No dependencies; used by abdt_mode_fsm and aim_dwell_burst_trigger.
package abdt_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned SQ_W    = 2 * COORD_W;
  localparam int unsigned REG_IDX_W = 3;

  localparam int unsigned S_DATA_W = 4 * COORD_W + TIME_W;
  localparam int unsigned M_DATA_W = 8;

  localparam logic [REG_IDX_W-1:0] REG_AIM_TOLERANCE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LOCK_MS       = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BURST_MS      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_COOLDOWN_MS   = 3'd3;

  typedef enum logic [1:0] {
    MODE_SEARCHING = 2'd0,
    MODE_LOCKING   = 2'd1,
    MODE_FIRING    = 2'd2,
    MODE_COOLDOWN  = 2'd3
  } mode_t;

  typedef struct packed {
    logic              step;
    logic              on_tgt;
    logic [TIME_W-1:0] now_ms;
  } fsm_in_t;

  typedef struct packed {
    logic  fire;
    mode_t mode;
  } fsm_out_t;

  typedef struct packed {
    logic [CFG_W-1:0] lock_ms;
    logic [CFG_W-1:0] burst_ms;
    logic [CFG_W-1:0] cool_ms;
  } timing_cfg_t;

endpackage

FILE: sv/abdt_mode_fsm.sv
// Mode controller: searching, locking, firing, cooldown, plus lock tracking.
// Depends on abdt_pkg and aim_dwell_burst_trigger_assert.svh.
`include "aim_dwell_burst_trigger_assert.svh"

module abdt_mode_fsm (
  input  logic                 clk,
  input  logic                 rst,
  input  abdt_pkg::fsm_in_t    fin,
  input  abdt_pkg::timing_cfg_t tcfg,
  output abdt_pkg::fsm_out_t   fout
);

  abdt_pkg::mode_t                 mode;
  abdt_pkg::mode_t                 mode_next;
  logic                            lock_valid;
  logic                            lock_valid_next;
  logic [abdt_pkg::TIME_W-1:0]     lock_start;
  logic [abdt_pkg::TIME_W-1:0]     lock_start_next;
  logic [abdt_pkg::TIME_W-1:0]     phase_start;
  logic [abdt_pkg::TIME_W-1:0]     phase_start_next;

  logic [abdt_pkg::TIME_W-1:0]     lock_start_pre;
  logic [abdt_pkg::TIME_W-1:0]     lock_elapsed;
  logic [abdt_pkg::TIME_W-1:0]     phase_elapsed;
  logic                            lock_done;
  logic                            burst_done;
  logic                            cool_done;

  // Lock tracking runs ahead of the mode logic: entering tolerance restarts it.
  assign lock_start_pre = (fin.on_tgt && !lock_valid) ? fin.now_ms : lock_start;

  assign lock_elapsed  = fin.now_ms - lock_start;
  assign phase_elapsed = fin.now_ms - phase_start;

  // A lock that starts on this word has zero elapsed time.
  assign lock_done  = fin.on_tgt &&
                      (lock_valid ?
                       (lock_elapsed >= {{(abdt_pkg::TIME_W-abdt_pkg::CFG_W){1'b0}},
                                         tcfg.lock_ms}) :
                       (tcfg.lock_ms == '0));
  assign burst_done = phase_elapsed >=
                      {{(abdt_pkg::TIME_W-abdt_pkg::CFG_W){1'b0}}, tcfg.burst_ms};
  assign cool_done  = phase_elapsed >=
                      {{(abdt_pkg::TIME_W-abdt_pkg::CFG_W){1'b0}}, tcfg.cool_ms};

  // Next state
  always_comb begin
    mode_next        = mode;
    lock_valid_next  = fin.on_tgt;
    lock_start_next  = lock_start_pre;
    phase_start_next = phase_start;
    unique case (mode)
      abdt_pkg::MODE_FIRING: begin
        if (burst_done) begin
          mode_next        = abdt_pkg::MODE_COOLDOWN;
          phase_start_next = fin.now_ms;
          lock_valid_next  = 1'b0;
        end
      end
      abdt_pkg::MODE_COOLDOWN: begin
        if (cool_done) begin
          mode_next = fin.on_tgt ? abdt_pkg::MODE_LOCKING : abdt_pkg::MODE_SEARCHING;
          if (fin.on_tgt) begin
            lock_start_next = fin.now_ms;
          end
        end
      end
      abdt_pkg::MODE_SEARCHING,
      abdt_pkg::MODE_LOCKING: begin
        mode_next = fin.on_tgt ? abdt_pkg::MODE_LOCKING : abdt_pkg::MODE_SEARCHING;
        if (lock_done) begin
          mode_next        = abdt_pkg::MODE_FIRING;
          phase_start_next = fin.now_ms;
          lock_valid_next  = 1'b0;
        end
      end
    endcase
  end

  // Outputs for the current word
  always_comb begin
    fout.mode = mode_next;
    unique case (mode)
      abdt_pkg::MODE_FIRING:    fout.fire = !burst_done;
      abdt_pkg::MODE_COOLDOWN:  fout.fire = 1'b0;
      abdt_pkg::MODE_SEARCHING,
      abdt_pkg::MODE_LOCKING:   fout.fire = lock_done;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= abdt_pkg::MODE_SEARCHING;
      lock_valid  <= 1'b0;
      lock_start  <= '0;
      phase_start <= '0;
    end else if (fin.step) begin
      mode        <= mode_next;
      lock_valid  <= lock_valid_next;
      lock_start  <= lock_start_next;
      phase_start <= phase_start_next;
    end
  end

  `ABDT_ASSERT_NEXT(a_fire_means_firing, fin.step && fout.fire,
    mode == abdt_pkg::MODE_FIRING, "fire raised but mode did not land in firing")
  `ABDT_ASSERT_NEXT(a_no_skip_to_cooldown,
    fin.step && (mode == abdt_pkg::MODE_SEARCHING || mode == abdt_pkg::MODE_LOCKING),
    mode != abdt_pkg::MODE_COOLDOWN, "cooldown entered without a burst")
  `ABDT_ASSERT_NEXT(a_firing_exits_to_cooldown,
    fin.step && mode == abdt_pkg::MODE_FIRING,
    mode == abdt_pkg::MODE_FIRING || mode == abdt_pkg::MODE_COOLDOWN,
    "firing left for a mode other than cooldown")
  `ABDT_ASSERT_NEXT(a_burst_start_clears_lock,
    fin.step && mode != abdt_pkg::MODE_FIRING && mode_next == abdt_pkg::MODE_FIRING,
    !lock_valid && phase_start == $past(fin.now_ms),
    "burst start did not clear lock or stamp phase start")
  `ABDT_ASSERT_NOW(a_cooldown_never_fires, mode == abdt_pkg::MODE_COOLDOWN,
    !fout.fire, "fire asserted during cooldown")

endmodule

FILE: sv/aim_dwell_burst_trigger.sv
// Aim dwell burst trigger: top level with stream ports, config registers
// and the distance check. Depends on abdt_pkg and abdt_mode_fsm.
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------------------
//  s_*      | s_tvalid/s_tready  | s_tdata: target_x, target_y, cross_x,
//           |                    |          cross_y, now_ms (96 bits)
//  m_*      | m_tvalid/m_tready  | m_tdata: fire, mode, on_target, zero pad
//  cfg_*    | cfg_we (no wait)   | cfg_index selects, cfg_data 16 bits
//
// An accepted word lands in the input register; its result goes through the
// output register to m_tdata, one word per cycle unless the output stalls.
// Between the two registers: two 16x16 squares, their sum against the squared
// tolerance, and one step of the mode controller, whose state loop closes
// in that same cycle.
// The input register advances when it is empty or the output register
// advances; with both full and m_tready low, s_tready drops.
// rst clears both valid bits, config registers and controller state.
module aim_dwell_burst_trigger (
  input  logic                             clk,
  input  logic                             rst,
  // target_x[15:0], target_y[31:16], cross_x[47:32], cross_y[63:48],
  // now_ms[95:64]
  input  logic [abdt_pkg::S_DATA_W-1:0]    s_tdata,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // fire[0], mode[2:1], on_target[3], zero[7:4]
  output logic [abdt_pkg::M_DATA_W-1:0]    m_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic                             cfg_we,
  input  logic [abdt_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [abdt_pkg::CFG_W-1:0]       cfg_data
);

  // Configuration registers
  logic [abdt_pkg::CFG_W-1:0] aim_tolerance;
  abdt_pkg::timing_cfg_t      tcfg;

  // Input register: captured word
  logic                          v1;
  logic [abdt_pkg::COORD_W-1:0]  target_x;
  logic [abdt_pkg::COORD_W-1:0]  target_y;
  logic [abdt_pkg::COORD_W-1:0]  cross_x;
  logic [abdt_pkg::COORD_W-1:0]  cross_y;
  logic [abdt_pkg::TIME_W-1:0]   now1;

  // Output register
  logic                          vo;
  logic [abdt_pkg::M_DATA_W-1:0] result;

  logic                          rdy_o;
  logic                          rdy1;
  logic [abdt_pkg::COORD_W-1:0]  dx;
  logic [abdt_pkg::COORD_W-1:0]  dy;
  logic [abdt_pkg::SQ_W-1:0]     sq_x;
  logic [abdt_pkg::SQ_W-1:0]     sq_y;
  logic [abdt_pkg::SQ_W-1:0]     tol_sq;
  logic [abdt_pkg::SQ_W:0]       dist_sq;
  logic                          on_target;
  abdt_pkg::fsm_in_t             fin;
  abdt_pkg::fsm_out_t            fout;

  assign rdy_o    = !vo || m_tready;
  assign rdy1     = !v1 || rdy_o;
  assign s_tready = rdy1;
  assign m_tvalid = vo;
  assign m_tdata  = result;

  // Config writes; indexes past the last register drop.
  always_ff @(posedge clk) begin
    if (rst) begin
      aim_tolerance <= '0;
      tcfg          <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        abdt_pkg::REG_AIM_TOLERANCE: aim_tolerance <= cfg_data;
        abdt_pkg::REG_LOCK_MS:       tcfg.lock_ms  <= cfg_data;
        abdt_pkg::REG_BURST_MS:      tcfg.burst_ms <= cfg_data;
        abdt_pkg::REG_COOLDOWN_MS:   tcfg.cool_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: capture the input word
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && s_tvalid) begin
      target_x <= s_tdata[15:0];
      target_y <= s_tdata[31:16];
      cross_x  <= s_tdata[47:32];
      cross_y  <= s_tdata[63:48];
      now1     <= s_tdata[95:64];
    end
  end

  // Absolute differences, then the two squares side by side
  always_comb begin
    dx = (target_x >= cross_x) ? (target_x - cross_x) : (cross_x - target_x);
    dy = (target_y >= cross_y) ? (target_y - cross_y) : (cross_y - target_y);
  end

  assign sq_x   = abdt_pkg::SQ_W'(dx) * abdt_pkg::SQ_W'(dx);
  assign sq_y   = abdt_pkg::SQ_W'(dy) * abdt_pkg::SQ_W'(dy);
  assign tol_sq = abdt_pkg::SQ_W'(aim_tolerance) * abdt_pkg::SQ_W'(aim_tolerance);

  // Compare and step the mode controller
  assign dist_sq   = {1'b0, sq_x} + {1'b0, sq_y};
  assign on_target = dist_sq <= {1'b0, tol_sq};

  assign fin.step   = v1 && rdy_o;
  assign fin.on_tgt = on_target;
  assign fin.now_ms = now1;

  abdt_mode_fsm u_mode_fsm (
    .clk  (clk),
    .rst  (rst),
    .fin  (fin),
    .tcfg (tcfg),
    .fout (fout)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (rdy_o) begin
      vo <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (fin.step) begin
      result <= {4'b0000, on_target, fout.mode, fout.fire};
    end
  end

endmodule

FILE: dv/aim_dwell_burst_trigger_tb.sv
// Testbench for aim_dwell_burst_trigger: directed dwell, burst, cooldown and
// timestamp-wrap cases, then randomized phases checked by a built-in predictor.
// Depends on abdt_pkg and the aim_dwell_burst_trigger RTL.
module aim_dwell_burst_trigger_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int          COORD_MAX     = (1 << abdt_pkg::COORD_W) - 1;
  // Smallest per-axis offset whose two squares exceed the largest tolerance.
  localparam int          DIAG_OFF_MIN  = 46341;

  // One input word, target_x in the lowest bits as on s_tdata.
  typedef struct packed {
    logic [abdt_pkg::TIME_W-1:0]  now_ms;
    logic [abdt_pkg::COORD_W-1:0] cross_y;
    logic [abdt_pkg::COORD_W-1:0] cross_x;
    logic [abdt_pkg::COORD_W-1:0] target_y;
    logic [abdt_pkg::COORD_W-1:0] target_x;
  } aim_sample_t;

  // One result word, fire in bit 0 as on m_tdata.
  typedef struct packed {
    logic [3:0]      pad;
    logic            on_target;
    abdt_pkg::mode_t mode;
    logic            fire;
  } trig_word_t;

  logic                             clk = 1'b0;
  logic                             rst;
  // target_x[15:0], target_y[31:16], cross_x[47:32], cross_y[63:48], now_ms[95:64]
  logic [abdt_pkg::S_DATA_W-1:0]    s_tdata;
  logic                             s_tvalid;
  logic                             s_tready;
  // fire[0], mode[2:1], on_target[3], zero[7:4]
  logic [abdt_pkg::M_DATA_W-1:0]    m_tdata;
  logic                             m_tvalid;
  logic                             m_tready;
  logic                             cfg_we;
  logic [abdt_pkg::REG_IDX_W-1:0]   cfg_index;
  logic [abdt_pkg::CFG_W-1:0]       cfg_data;

  // Predictor copy of the registers and the trigger state.
  logic [abdt_pkg::CFG_W-1:0]  tol_cfg   = '0;
  logic [abdt_pkg::CFG_W-1:0]  lock_cfg  = '0;
  logic [abdt_pkg::CFG_W-1:0]  burst_cfg = '0;
  logic [abdt_pkg::CFG_W-1:0]  cool_cfg  = '0;
  abdt_pkg::mode_t             trig_mode = abdt_pkg::MODE_SEARCHING;
  logic                        lock_held = 1'b0;
  logic [abdt_pkg::TIME_W-1:0] lock_t0   = '0;
  logic [abdt_pkg::TIME_W-1:0] phase_t0  = '0;

  trig_word_t  expected_triggers[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned word_count     = 0;
  bit          calm_run       = 1'b0;

  aim_dwell_burst_trigger DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic [abdt_pkg::TIME_W-1:0] ms_since(
      logic [abdt_pkg::TIME_W-1:0] now, logic [abdt_pkg::TIME_W-1:0] start);
    return now - start;
  endfunction

  // Advance the trigger state by one word and return the word it produces.
  function automatic trig_word_t step_trigger(aim_sample_t s);
    logic [63:0] dx, dy, dist_sq, tol_sq;
    logic        on_tgt;
    trig_word_t  r;
    dx = (s.target_x >= s.cross_x) ? s.target_x - s.cross_x : s.cross_x - s.target_x;
    dy = (s.target_y >= s.cross_y) ? s.target_y - s.cross_y : s.cross_y - s.target_y;
    dist_sq = dx * dx + dy * dy;
    tol_sq  = {48'd0, tol_cfg} * {48'd0, tol_cfg};
    on_tgt  = (dist_sq <= tol_sq);
    r = '0;
    r.on_target = on_tgt;

    // Lock tracking runs ahead of the mode logic in every mode.
    if (!on_tgt) begin
      lock_held = 1'b0;
    end else if (!lock_held) begin
      lock_held = 1'b1;
      lock_t0   = s.now_ms;
    end

    case (trig_mode)
      abdt_pkg::MODE_FIRING: begin
        if (ms_since(s.now_ms, phase_t0) >= burst_cfg) begin
          trig_mode = abdt_pkg::MODE_COOLDOWN;
          phase_t0  = s.now_ms;
          lock_held = 1'b0;
        end else begin
          r.fire = 1'b1;
        end
      end
      abdt_pkg::MODE_COOLDOWN: begin
        if (ms_since(s.now_ms, phase_t0) >= cool_cfg) begin
          trig_mode = on_tgt ? abdt_pkg::MODE_LOCKING : abdt_pkg::MODE_SEARCHING;
          if (on_tgt) begin
            lock_held = 1'b1;
            lock_t0   = s.now_ms;
          end
        end
      end
      default: begin
        trig_mode = on_tgt ? abdt_pkg::MODE_LOCKING : abdt_pkg::MODE_SEARCHING;
        if (on_tgt && lock_held && ms_since(s.now_ms, lock_t0) >= lock_cfg) begin
          trig_mode = abdt_pkg::MODE_FIRING;
          phase_t0  = s.now_ms;
          lock_held = 1'b0;
          r.fire    = 1'b1;
        end
      end
    endcase
    r.mode = trig_mode;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stream drivers and result checker
  // ---------------------------------------------------------------------------
  function automatic int idle_gap();
    return calm_run ? 0 : int'($urandom_range(0, 15));
  endfunction

  // Enter and leave at a falling edge; keep tvalid high if the next word
  // follows without a gap.
  task automatic send_sample(aim_sample_t s);
    int gap;
    gap = idle_gap();
    if (gap != 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  = s;
    s_tvalid = 1'b1;
    do @(posedge clk); while (s_tready !== 1'b1);
    expected_triggers.push_back(step_trigger(s));
    @(negedge clk);
  endtask

  task automatic send_point(int tx, int ty, int cx, int cy,
                            logic [abdt_pkg::TIME_W-1:0] t);
    aim_sample_t s;
    s.target_x = abdt_pkg::COORD_W'(tx);
    s.target_y = abdt_pkg::COORD_W'(ty);
    s.cross_x  = abdt_pkg::COORD_W'(cx);
    s.cross_y  = abdt_pkg::COORD_W'(cy);
    s.now_ms   = t;
    send_sample(s);
  endtask

  // Result side: drop tready for a random idle gap, if any, then hold tready until
  // one word has gone through.
  initial begin : drain_results
    int gap;
    m_tready = 1'b0;
    forever begin
      gap = idle_gap();
      if (gap != 0) begin
        m_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      @(negedge clk);
    end
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("ERROR word %0d: %s, got %0d, want %0d", word_count, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check_results
    trig_word_t got, want;
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      got = trig_word_t'(m_tdata);
      if (expected_triggers.size() == 0) begin
        report_mismatch("word with none pending", longint'(m_tdata), longint'(0));
      end else begin
        want = expected_triggers.pop_front();
        if (got.fire !== want.fire)
          report_mismatch("fire", longint'(got.fire), longint'(want.fire));
        if (got.mode !== want.mode)
          report_mismatch("mode", longint'(got.mode), longint'(want.mode));
        if (got.on_target !== want.on_target)
          report_mismatch("on_target", longint'(got.on_target), longint'(want.on_target));
        if (got.pad !== want.pad)
          report_mismatch("pad bits", longint'(got.pad), longint'(want.pad));
      end
      word_count++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  task automatic wait_idle();
    s_tvalid = 1'b0;
    while (expected_triggers.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [abdt_pkg::REG_IDX_W-1:0] idx,
                           logic [abdt_pkg::CFG_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    case (idx)
      abdt_pkg::REG_AIM_TOLERANCE: tol_cfg   = value;
      abdt_pkg::REG_LOCK_MS:       lock_cfg  = value;
      abdt_pkg::REG_BURST_MS:      burst_cfg = value;
      abdt_pkg::REG_COOLDOWN_MS:   cool_cfg  = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic apply_settings(int tol, int lock, int burst, int cool);
    wait_idle();
    write_reg(abdt_pkg::REG_AIM_TOLERANCE, abdt_pkg::CFG_W'(tol));
    write_reg(abdt_pkg::REG_LOCK_MS,       abdt_pkg::CFG_W'(lock));
    write_reg(abdt_pkg::REG_BURST_MS,      abdt_pkg::CFG_W'(burst));
    write_reg(abdt_pkg::REG_COOLDOWN_MS,   abdt_pkg::CFG_W'(cool));
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Registers at their reset value: zero radius, all durations zero.
  task automatic test_zero_config();
    send_point(0, 0, 0, 0, 0);                          // fire on first hit
    send_point(0, 0, 0, 0, 0);                          // zero burst ends at once
    send_point(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0); // cooldown ends, lock
    send_point(0, COORD_MAX, COORD_MAX, 0, '1);         // far apart, back to search
  endtask

  // Writes beyond the last register must leave the settings untouched.
  task automatic test_ignored_index();
    wait_idle();
    for (int idx = int'(abdt_pkg::REG_COOLDOWN_MS) + 1; idx < (1 << abdt_pkg::REG_IDX_W);
         idx++)
      write_reg(abdt_pkg::REG_IDX_W'(idx), '1);
    send_point(300, 300, 300, 300, 100);                // still fires at once
    send_point(300, 300, 301, 300, 101);                // radius still zero
  endtask

  // Full dwell, burst and cooldown sequence, with the radius rim hit exactly.
  task automatic test_dwell_burst_cooldown();
    apply_settings(160, 100, 50, 80);
    send_point(1000, 2000, 1160, 2000, 5000);           // on the rim
    send_point(1000, 2000, 1160, 2001, 5040);           // just outside, lock drops
    send_point(1000, 2000, 1000, 2000, 5060);
    send_point(1000, 2000, 1000, 2000, 5159);           // one ms short of lock
    send_point(1000, 2000, 1000, 2000, 5160);           // fire
    send_point(1000, 2000, 4000, 2000, 5200);           // off target, still firing
    send_point(1000, 2000, 1000, 2000, 5210);           // burst over
    send_point(1000, 2000, 1000, 2000, 5289);
    send_point(1000, 2000, 1000, 2000, 5290);           // cooldown over, on target
    send_point(1000, 2000, 1000, 2000, 5390);           // fire again
    send_point(1000, 2000, 9000, 9000, 5440);
    send_point(1000, 2000, 9000, 9000, 5520);           // cooldown over, off target
  endtask

  // Timestamps that wrap and then step backward.
  task automatic test_time_wrap();
    apply_settings(32, 20, 10, 10);
    send_point(500, 500, 500, 500, 32'hFFFF_FFF0);
    send_point(500, 500, 500, 500, 32'h0000_0004);      // lock time across the wrap
    send_point(500, 500, 500, 500, 32'h0000_0003);      // backward: burst ends
    send_point(500, 500, 500, 500, 32'h0000_0002);      // backward: cooldown ends
  endtask

  // Largest radius and durations.
  task automatic test_full_scale_config();
    apply_settings(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    send_point(0, 0, COORD_MAX, COORD_MAX, 0);          // diagonal is beyond reach
    send_point(0, 0, COORD_MAX, 0, 10);                 // on the rim
    send_point(0, 0, COORD_MAX, 0, 65544);
    send_point(0, 0, COORD_MAX, 0, 65545);              // full lock time reached
  endtask

  // ---------------------------------------------------------------------------
  // Random phases
  // ---------------------------------------------------------------------------
  function automatic logic [abdt_pkg::COORD_W-1:0] offset_coord(
      logic [abdt_pkg::COORD_W-1:0] c, int d);
    int cv;
    cv = c;
    if (cv + d <= COORD_MAX && (cv < d || $urandom_range(0, 1) == 1))
      return abdt_pkg::COORD_W'(cv + d);
    if (cv >= d)
      return abdt_pkg::COORD_W'(cv - d);
    return '1;
  endfunction

  // Build a word whose crosshair is placed inside or outside the radius.
  function automatic aim_sample_t aim_point(bit on, logic [abdt_pkg::TIME_W-1:0] t);
    aim_sample_t s;
    int          tol, dx, dy;
    tol = tol_cfg;
    s.target_x = abdt_pkg::COORD_W'($urandom());
    s.target_y = abdt_pkg::COORD_W'($urandom());
    if (on) begin
      dx = $urandom_range(0, tol / 2);
      dy = $urandom_range(0, tol / 2);
      if ($urandom_range(0, 9) == 0) begin
        dx = tol;
        dy = 0;
      end
    end else if (tol >= DIAG_OFF_MIN) begin
      dx = $urandom_range(DIAG_OFF_MIN, COORD_MAX);
      dy = $urandom_range(DIAG_OFF_MIN, COORD_MAX);
    end else begin
      dx = $urandom_range(tol + 1, COORD_MAX);
      dy = $urandom_range(0, COORD_MAX);
    end
    s.cross_x = offset_coord(s.target_x, dx);
    s.cross_y = offset_coord(s.target_y, dy);
    s.now_ms  = t;
    return s;
  endfunction

  // Mostly runs of aiming on and off with advancing time; some noise words
  // and some jumps of the clock anywhere in its range.
  task automatic run_random_phase(int unsigned count, int unsigned step_max);
    aim_sample_t                 s;
    logic [abdt_pkg::TIME_W-1:0] clock_ms;
    bit                          aiming;
    clock_ms = $urandom();
    aiming   = 1'b1;
    repeat (count) begin
      if ($urandom_range(0, 7) == 0)
        aiming = !aiming;
      if ($urandom_range(0, 9) == 0)
        clock_ms = $urandom();
      else
        clock_ms += $urandom_range(0, step_max);
      if ($urandom_range(0, 6) == 0) begin
        s.target_x = abdt_pkg::COORD_W'($urandom());
        s.target_y = abdt_pkg::COORD_W'($urandom());
        s.cross_x  = abdt_pkg::COORD_W'($urandom());
        s.cross_y  = abdt_pkg::COORD_W'($urandom());
        s.now_ms   = clock_ms;
      end else begin
        s = aim_point(aiming, clock_ms);
      end
      send_sample(s);
    end
  endtask

  task automatic test_random_phases();
    // Typical dwell settings with idling on both sides.
    calm_run = 1'b0;
    apply_settings($urandom_range(16, 800), $urandom_range(20, 200),
                   $urandom_range(10, 100), $urandom_range(10, 100));
    run_random_phase(110, 40);
    // Zero durations, back to back words.
    calm_run = 1'b1;
    apply_settings($urandom_range(0, 2000), 0, 0, 0);
    run_random_phase(110, 20);
    // Any settings, large time steps.
    calm_run = 1'b0;
    apply_settings($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                   $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
    run_random_phase(110, 80000);
    // Zero radius: only exact hits count.
    calm_run = 1'b1;
    apply_settings(0, $urandom_range(0, 60), $urandom_range(0, 60), $urandom_range(0, 60));
    run_random_phase(110, 30);
    // Largest radius.
    calm_run = 1'b0;
    apply_settings(COORD_MAX, $urandom_range(0, 300), $urandom_range(0, 300),
                   $urandom_range(0, 300));
    run_random_phase(110, 50);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : run_tests
    rst       = 1'b1;
    s_tdata   = '0;
    s_tvalid  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = abdt_pkg::REG_AIM_TOLERANCE;
    cfg_data  = '0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    test_zero_config();
    test_ignored_index();
    test_dwell_burst_cooldown();
    test_time_wrap();
    test_full_scale_config();
    test_random_phases();

    wait_idle();
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/abdt_pkg.sv
sv/abdt_mode_fsm.sv
sv/aim_dwell_burst_trigger.sv
dv/aim_dwell_burst_trigger_tb.sv
